// ===== hdl/rls_pkg.sv =====
package rls_pkg;

  localparam int GAP_W = 6;
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(8);

  // controller -> datapath
  typedef struct packed {
    logic load;     // input transfer: update run state, load a burst if any
    logic advance;  // output transfer: step the burst count
  } rls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_burst;   // the offered pixel releases at least one result
    logic final_beat;  // the current result is the last of its burst
  } rls_sts_t;

endpackage

// ===== hdl/rls_if.sv =====
interface rls_pix_in_if;
  logic valid;
  logic ready;
  logic pixel_black;
  logic line_end;

  modport source(output valid, pixel_black, line_end, input ready);
  modport sink(input valid, pixel_black, line_end, output ready);
endinterface

interface rls_pix_out_if;
  logic valid;
  logic ready;
  logic out_black;
  logic out_line_end;
  logic last_of_burst;

  modport source(output valid, out_black, out_line_end, last_of_burst, input ready);
  modport sink(input valid, out_black, out_line_end, last_of_burst, output ready);
endinterface

interface rls_cfg_if;
  import rls_pkg::*;
  logic             valid;
  logic             ready;
  logic [GAP_W-1:0] gap_limit;

  modport source(output valid, gap_limit, input ready);
  modport sink(input valid, gap_limit, output ready);
endinterface

// ===== hdl/rls_ctrl.sv =====
module rls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rls_pkg::rls_sts_t sts,
  output rls_pkg::rls_cmd_t cmd
);
  import rls_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign out_valid = (state_r == ST_EMIT);
  // take the next pixel in the cycle the final result of a burst transfers
  assign in_ready  = (state_r == ST_IDLE) || (sts.final_beat && out_ready);
  assign take      = in_valid && in_ready;

  assign cmd.load    = take;
  assign cmd.advance = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && sts.has_burst) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.final_beat) begin
          state_nxt = (take && sts.has_burst) ? ST_EMIT : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/rls_dp.sv =====
module rls_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [rls_pkg::GAP_W-1:0] cfg_gap_limit,
  input  logic                      pixel_black,
  input  logic                      line_end,
  input  rls_pkg::rls_cmd_t         cmd,
  output rls_pkg::rls_sts_t         sts,
  output logic                      out_black,
  output logic                      out_line_end,
  output logic                      last_of_burst
);
  import rls_pkg::*;

  logic [GAP_W-1:0] gap_r;
  logic [GAP_W-1:0] held_r, held_nxt;
  logic             ovf_r, ovf_nxt;
  logic [GAP_W-1:0] cnt_r;      // results left in the burst, minus one
  logic             color_r;
  logic             lend_r;

  logic             has_burst;
  logic [GAP_W-1:0] burst_cnt;
  logic             burst_color;

  always_comb begin
    has_burst   = 1'b1;
    burst_cnt   = '0;
    burst_color = 1'b0;
    held_nxt    = '0;
    ovf_nxt     = 1'b0;
    priority if (pixel_black) begin
      // fill the held gap unless the run already went past the limit
      burst_color = 1'b1;
      burst_cnt   = ovf_r ? '0 : held_r;
    end else if (ovf_r) begin
      ovf_nxt = !line_end;
    end else if (held_r >= gap_r) begin
      burst_cnt = held_r;
      ovf_nxt   = !line_end;
    end else if (line_end) begin
      burst_cnt = held_r;
    end else begin
      has_burst = 1'b0;
      held_nxt  = held_r + GAP_W'(1);
    end
  end

  assign sts.has_burst  = has_burst;
  assign sts.final_beat = (cnt_r == '0);

  assign out_black     = color_r;
  assign out_line_end  = lend_r && (cnt_r == '0);
  assign last_of_burst = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= GAP_RESET;
      held_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cfg_valid) gap_r <= cfg_gap_limit;
      if (cmd.load) begin
        held_r <= held_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && has_burst) begin
      cnt_r   <= burst_cnt;
      color_r <= burst_color;
      lend_r  <= line_end;
    end else if (cmd.advance && (cnt_r != '0)) begin
      cnt_r <= cnt_r - GAP_W'(1);
    end
  end

endmodule

// ===== hdl/run_length_smoothing.sv =====
// Run-length smoothing of a binary pixel line.
// The first result of a pixel appears in the cycle after its input transfer.
// A pixel may release a burst of results, one result a cycle from the burst counter
// while out_px.ready is high; the next pixel is taken only as the final result transfers.
// Reset (rst_n, synchronous, active low): idle, no held run, gap_limit = 8.
module run_length_smoothing (
  input logic                clk,
  input logic                rst_n,
  rls_pix_in_if.sink         in_px,
  rls_pix_out_if.source      out_px,
  rls_cfg_if.sink            cfg_wr
);
  import rls_pkg::*;

  rls_cmd_t cmd;
  rls_sts_t sts;

  assign cfg_wr.ready = 1'b1;

  rls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rls_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_wr.valid),
    .cfg_gap_limit (cfg_wr.gap_limit),
    .pixel_black   (in_px.pixel_black),
    .line_end      (in_px.line_end),
    .cmd           (cmd),
    .sts           (sts),
    .out_black     (out_px.out_black),
    .out_line_end  (out_px.out_line_end),
    .last_of_burst (out_px.last_of_burst)
  );

  // a new pixel enters during a burst only as its final result transfers
  a_take_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (in_px.valid && in_px.ready && out_px.valid) |->
      (out_px.last_of_burst && out_px.ready))
    else $error("pixel taken in the middle of a burst");

  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_px.valid && out_px.out_line_end) |-> out_px.last_of_burst)
    else $error("line end flagged before the end of a burst");

  a_black_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_px.valid && in_px.ready && in_px.pixel_black) |=> out_px.valid)
    else $error("black pixel released no result");

endmodule

// ===== tb/sv/rls_checker.sv =====
`timescale 1ns / 1ps
module rls_checker (
  input  logic   clk,
  input  logic   rst_n,
  rls_pix_in_if  in_ch,
  rls_pix_out_if out_ch,
  rls_cfg_if     cfg_ch,
  output int     fail_count,
  output int     pending
);
  import rls_pkg::*;

  typedef struct packed {
    logic black;
    logic line_end;
    logic last_of_burst;
  } smooth_px_t;

  smooth_px_t       smoothed_q[$];
  logic [GAP_W-1:0] gap_limit;
  logic [GAP_W-1:0] held_whites;
  logic             run_overflowed;

  // Every burst is one color: filled or plain black, or released whites.
  task automatic smooth_pixel(input logic black, input logic last);
    int         count;
    logic       color;
    smooth_px_t px;
    count = 0;
    color = 1'b0;
    if (black) begin
      count = run_overflowed ? 1 : int'(held_whites) + 1;
      color = 1'b1;
      held_whites = '0;
      run_overflowed = 1'b0;
    end else if (run_overflowed) begin
      count = 1;
    end else if (held_whites >= gap_limit) begin
      count = int'(held_whites) + 1;
      held_whites = '0;
      run_overflowed = 1'b1;
    end else if (last) begin
      count = int'(held_whites) + 1;
      held_whites = '0;
    end else begin
      held_whites = held_whites + 1'b1;
    end
    if (last) begin
      held_whites = '0;
      run_overflowed = 1'b0;
    end
    for (int i = 0; i < count; i++) begin
      px.black = color;
      px.line_end = last && (i == count - 1);
      px.last_of_burst = (i == count - 1);
      smoothed_q.push_back(px);
    end
  endtask

  always @(posedge clk) begin
    smooth_px_t exp_px;
    if (!rst_n) begin
      gap_limit = GAP_RESET;
      held_whites = '0;
      run_overflowed = 1'b0;
      smoothed_q.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        smooth_pixel(in_ch.pixel_black, in_ch.line_end);
      if (out_ch.valid && out_ch.ready) begin
        if (smoothed_q.size() == 0) begin
          $error("result transfer with nothing expected: out_black %0b out_line_end %0b",
                 out_ch.out_black, out_ch.out_line_end);
          fail_count++;
        end else begin
          exp_px = smoothed_q.pop_front();
          if (out_ch.out_black !== exp_px.black) begin
            $error("out_black: expected %0b, actual %0b", exp_px.black, out_ch.out_black);
            fail_count++;
          end
          if (out_ch.out_line_end !== exp_px.line_end) begin
            $error("out_line_end: expected %0b, actual %0b",
                   exp_px.line_end, out_ch.out_line_end);
            fail_count++;
          end
          if (out_ch.last_of_burst !== exp_px.last_of_burst) begin
            $error("last_of_burst: expected %0b, actual %0b",
                   exp_px.last_of_burst, out_ch.last_of_burst);
            fail_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready)
        gap_limit = cfg_ch.gap_limit;
    end
    pending <= smoothed_q.size();
  end

endmodule

// ===== tb/sv/tb_run_length_smoothing.sv =====
`timescale 1ns / 1ps
module tb_run_length_smoothing;
  import rls_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycles = 0;
  int   items_sent = 0;

  rls_pix_in_if  in_ch();
  rls_pix_out_if out_ch();
  rls_cfg_if     cfg_ch();

  always #2 clk = ~clk;

  run_length_smoothing dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_ch),
    .out_px (out_ch),
    .cfg_wr (cfg_ch)
  );

  rls_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run_length_smoothing test failed");
      $finish;
    end
  end

  task automatic send(input logic black, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.pixel_black <= 1'($urandom_range(1));
      in_ch.line_end <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_black <= black;
    in_ch.line_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Hold the input until every expected result has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.gap_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly white runs around the limit, split by black; some noise.
  // Send at most budget pixels; close the line early when the budget runs out.
  task automatic random_line(input int gap, input int budget);
    logic pix_q[$];
    int   segs;
    int   wlen;
    logic last;
    segs = $urandom_range(3, 1);
    for (int s = 0; s < segs; s++) begin
      wlen = 0;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: wlen = $urandom_range(gap);
        5:             wlen = gap;
        6, 7:          wlen = gap + $urandom_range(3, 1);
        8:             wlen = $urandom_range(66);
        default: begin
          repeat ($urandom_range(4, 1)) pix_q.push_back(1'($urandom_range(1)));
        end
      endcase
      repeat (wlen) pix_q.push_back(1'b0);
      if (s < segs - 1 || $urandom_range(1))
        repeat ($urandom_range(2, 1)) pix_q.push_back(1'b1);
    end
    if (pix_q.size() == 0)
      pix_q.push_back(1'($urandom_range(1)));
    foreach (pix_q[i]) begin
      if (i < budget) begin
        last = (i == pix_q.size() - 1) || (i == budget - 1) ||
               ($urandom_range(24) == 0);
        send(pix_q[i], last);
      end
    end
  endtask

  initial begin
    int phase_gap[7];
    int phase_end;
    phase_gap = '{5, 63, 21, 42, 0, 63, 2};
    in_ch.valid = 1'b0;
    in_ch.pixel_black = 1'b0;
    in_ch.line_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.gap_limit = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of 8: leading whites filled, held whites released at line end
    send(1'b0, 1'b0); send(1'b0, 1'b0); send(1'b1, 1'b0);
    send(1'b0, 1'b0); send(1'b0, 1'b0); send(1'b0, 1'b1);
    send(1'b1, 1'b1); send(1'b0, 1'b1);
    // nine whites overflow the limit, later whites pass through
    send(1'b1, 1'b0);
    repeat (9) send(1'b0, 1'b0);
    send(1'b0, 1'b0); send(1'b0, 1'b1);
    wait_idle();

    // limit zero: nothing is ever filled
    write_gap(GAP_W'(0));
    send(1'b1, 1'b0); send(1'b0, 1'b0); send(1'b1, 1'b1);
    wait_idle();

    // top limit: longest fill, then longest release
    write_gap(GAP_W'(63));
    repeat (63) send(1'b0, 1'b0);
    send(1'b1, 1'b0);
    repeat (64) send(1'b0, 1'b0);
    send(1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      write_gap(GAP_W'(phase_gap[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        random_line(phase_gap[p], phase_end - items_sent);
        if ($urandom_range(9) == 0)
          wait_idle();
      end
      wait_idle();
    end

    stall_pct = 0;
    wait_idle();
    if (fail_count == 0)
      $display("run_length_smoothing test passed");
    else
      $display("run_length_smoothing test failed");
    $finish;
  end

endmodule
